### src/wsfp_pkg.sv
`timescale 1ns / 1ps
// Package with the shared types and constants of the WebSocket frame receive parser.
package wsfp_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_STOP    = 3'd5
    } t_phase;

    localparam logic [1:0] KIND_BINARY = 2'd0;
    localparam logic [1:0] KIND_PING   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_CLOSE      = 3'd1;
    localparam logic [2:0] ERR_FRAGMENTED = 3'd2;
    localparam logic [2:0] ERR_OPCODE     = 3'd3;
    localparam logic [2:0] ERR_PING_SIZE  = 3'd4;

    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last;
        logic [2:0] error_code;
    } t_result;

endpackage

### src/wsfp_parse.sv
`timescale 1ns / 1ps
// Frame header parser, unmasking and result generation for one received word per cycle.
module wsfp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    output logic                o_res_valid,
    output wsfp_pkg::t_result   o_res
);

    wsfp_pkg::t_phase r_phase, n_phase;
    logic             r_fin, n_fin;
    logic [3:0]       r_op, n_op;
    logic             r_mask, n_mask;
    logic [63:0]      r_len, n_len;
    logic [63:0]      r_cnt, n_cnt;
    logic [31:0]      r_key, n_key;

    function automatic logic [2:0] frame_error(input logic fin, input logic [3:0] op,
                                               input logic [63:0] len);
        logic [2:0] err;
        begin
            if (!fin) begin
                err = wsfp_pkg::ERR_FRAGMENTED;
            end else if (op == wsfp_pkg::OP_BINARY || op == wsfp_pkg::OP_PONG) begin
                err = wsfp_pkg::ERR_NONE;
            end else if (op == wsfp_pkg::OP_PING) begin
                err = (|len[63:16]) ? wsfp_pkg::ERR_PING_SIZE : wsfp_pkg::ERR_NONE;
            end else if (op == wsfp_pkg::OP_CLOSE) begin
                err = wsfp_pkg::ERR_CLOSE;
            end else begin
                err = wsfp_pkg::ERR_OPCODE;
            end
            return err;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wsfp_pkg::PH_HDR0;
            r_fin   <= 1'b0;
            r_op    <= '0;
            r_mask  <= 1'b0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_key   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fin   <= n_fin;
            r_op    <= n_op;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_key   <= n_key;
        end
    end

    logic        len_done;
    logic        start;
    logic [63:0] len_v;
    logic [63:0] cnt_inc;
    logic        at_end;
    logic [2:0]  err;
    logic [7:0]  key_byte;

    always_comb begin
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_op        = r_op;
        n_mask      = r_mask;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_key       = r_key;
        o_res_valid = 1'b0;
        o_res       = '0;
        len_done    = 1'b0;
        start       = 1'b0;
        len_v       = r_len;
        cnt_inc     = r_cnt + 64'd1;
        at_end      = (cnt_inc == r_len);
        err         = wsfp_pkg::ERR_NONE;
        key_byte    = 8'd0;

        if (i_fire) begin
            unique case (r_phase)
                wsfp_pkg::PH_HDR0: begin
                    n_fin   = i_byte[7];
                    n_op    = i_byte[3:0];
                    n_phase = wsfp_pkg::PH_HDR1;
                end
                wsfp_pkg::PH_HDR1: begin
                    n_mask = i_byte[7];
                    if (i_byte[6:0] == wsfp_pkg::LEN_CODE_16
                            || i_byte[6:0] == wsfp_pkg::LEN_CODE_64) begin
                        n_len   = '0;
                        n_cnt   = (i_byte[6:0] == wsfp_pkg::LEN_CODE_16) ? 64'd2 : 64'd8;
                        n_phase = wsfp_pkg::PH_EXT;
                    end else begin
                        len_v    = {57'd0, i_byte[6:0]};
                        n_len    = len_v;
                        len_done = 1'b1;
                    end
                end
                wsfp_pkg::PH_EXT: begin
                    len_v = {r_len[55:0], i_byte};
                    n_len = len_v;
                    n_cnt = r_cnt - 64'd1;
                    if (r_cnt[3:0] == 4'd1) begin
                        len_done = 1'b1;
                    end
                end
                wsfp_pkg::PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = r_cnt - 64'd1;
                    if (r_cnt[2:0] == 3'd1) begin
                        start = 1'b1;
                    end
                end
                wsfp_pkg::PH_PAYLOAD: begin
                    if (r_mask) begin
                        unique case (r_cnt[1:0])
                            2'd0:    key_byte = r_key[31:24];
                            2'd1:    key_byte = r_key[23:16];
                            2'd2:    key_byte = r_key[15:8];
                            default: key_byte = r_key[7:0];
                        endcase
                    end
                    n_cnt = cnt_inc;
                    err   = frame_error(r_fin, r_op, r_len);
                    if (err != wsfp_pkg::ERR_NONE) begin
                        if (at_end) begin
                            n_phase          = wsfp_pkg::PH_STOP;
                            o_res_valid      = 1'b1;
                            o_res.kind       = wsfp_pkg::KIND_ERROR;
                            o_res.last       = 1'b1;
                            o_res.error_code = err;
                        end
                    end else begin
                        if (at_end) begin
                            n_phase = wsfp_pkg::PH_HDR0;
                        end
                        if (r_op != wsfp_pkg::OP_PONG) begin
                            o_res_valid      = 1'b1;
                            o_res.kind       = (r_op == wsfp_pkg::OP_PING)
                                               ? wsfp_pkg::KIND_PING : wsfp_pkg::KIND_BINARY;
                            o_res.data_byte  = i_byte ^ key_byte;
                            o_res.data_valid = 1'b1;
                            o_res.last       = at_end;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (len_done) begin
                if (n_mask) begin
                    n_cnt   = 64'd4;
                    n_phase = wsfp_pkg::PH_MASK;
                end else begin
                    start = 1'b1;
                end
            end

            if (start) begin
                n_cnt = '0;
                if (len_v != 64'd0) begin
                    n_phase = wsfp_pkg::PH_PAYLOAD;
                end else begin
                    err = frame_error(r_fin, r_op, len_v);
                    if (err != wsfp_pkg::ERR_NONE) begin
                        n_phase          = wsfp_pkg::PH_STOP;
                        o_res_valid      = 1'b1;
                        o_res.kind       = wsfp_pkg::KIND_ERROR;
                        o_res.last       = 1'b1;
                        o_res.error_code = err;
                    end else begin
                        n_phase = wsfp_pkg::PH_HDR0;
                        if (r_op != wsfp_pkg::OP_PONG) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = (r_op == wsfp_pkg::OP_PING)
                                          ? wsfp_pkg::KIND_PING : wsfp_pkg::KIND_BINARY;
                            o_res.last  = 1'b1;
                        end
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == wsfp_pkg::PH_STOP |=> r_phase == wsfp_pkg::PH_STOP)
        else $error("parser left the stopped phase without reset");
    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == wsfp_pkg::KIND_ERROR |=> r_phase == wsfp_pkg::PH_STOP)
        else $error("error result not followed by the stopped phase");
    a_data_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.data_valid |-> r_phase == wsfp_pkg::PH_PAYLOAD)
        else $error("payload word produced outside the payload phase");
`endif

endmodule

### src/websocket_frame_receive_parser.sv
`timescale 1ns / 1ps
// Top level of the WebSocket frame receive parser with input register and output skid stage.
// Each accepted word is held in the input register, parsed, and its result registered in the output
// register, or in the skid register when the output register is full and not being taken.
// Throughput: one received word per cycle while the output side keeps taking results.
// The output register plus a one-entry skid register keep the input ready independent of
// the output ready. Synchronous active-low reset returns the parser to the first header
// byte, empties the stages, and clears the stopped state that follows an error result.
module websocket_frame_receive_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [7:0] data_byte, [10:8] error_code, rest zero
    output logic [2:0]  o_m_axis_tuser,  // [1:0] kind, [2] data_valid
    output logic        o_m_axis_tlast
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              fire;
    logic              res_valid;
    wsfp_pkg::t_result res;
    logic              r_out_valid;
    wsfp_pkg::t_result r_out;
    logic              r_skid_valid;
    wsfp_pkg::t_result r_skid;
    logic              in_acc;
    logic              pop;

    assign fire            = r_in_valid && !r_skid_valid;
    assign o_s_axis_tready = !r_in_valid || fire;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    wsfp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (fire && res_valid) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (fire && res_valid) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.error_code, r_out.data_byte};
    assign o_m_axis_tuser  = {r_out.data_valid, r_out.kind};
    assign o_m_axis_tlast  = r_out.last;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a word while the output register is empty");
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == wsfp_pkg::KIND_ERROR |-> r_out.last && !r_out.data_valid)
        else $error("error result without last or with payload");
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled input word was lost or changed");
`endif

endmodule
